FILE: hw/rtl/vses_pkg.sv
// Shared types, constants and the alpha lookup table for the variable-step smoother.
// Used by vses_front, vses_cmd_queue, vses_back and variable_step_ema_smoother.
package vses_pkg;

  localparam int CHANNELS     = 64;
  localparam int CH_W         = 6;
  localparam int DATA_W       = 16;
  localparam int ALPHA_DEPTH  = 256;
  localparam int ALPHA_IDX_W  = $clog2(ALPHA_DEPTH);
  localparam int PROD_W       = 32;
  localparam int ALPHA_SHIFT  = 27 - ALPHA_IDX_W;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0]  REG_SMOOTHING_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_INV_TAU          = 1'd1;
  localparam logic [DATA_W-1:0]     INV_TAU_RESET        = 16'd5120;

  typedef logic [DATA_W-1:0] alpha_tab_t [ALPHA_DEPTH];

  typedef struct packed {
    logic [CH_W-1:0]          channel;
    logic [DATA_W-1:0]        speed;
    logic signed [DATA_W-1:0] accel;
    logic                     smooth;
    logic [DATA_W-1:0]        alpha;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0]        speed;
    logic signed [DATA_W-1:0] accel;
  } res_t;

  function automatic alpha_tab_t build_alpha_tab();
    alpha_tab_t tab;
    logic [63:0] hq;
    logic [63:0] term;
    logic [63:0] q;
    logic [63:0] q2;
    logic [63:0] e;
    logic [63:0] one;
    logic [63:0] a;
    hq   = 64'd17179869184 / 64'(ALPHA_DEPTH);
    term = 64'd4294967296;
    one  = 64'd4294967296;
    q    = '0;
    for (int k = 0; k < 13; k++) begin
      if (k % 2 == 1) q = q - term;
      else            q = q + term;
      term = ((term * hq) >> 32) / 64'(k + 1);
    end
    q2 = (q * q) >> 32;
    e  = q;
    for (int i = 0; i < ALPHA_DEPTH; i++) begin
      a = (e < one) ? ((one - e) >> 16) : 64'd0;
      if (a > 64'd65535) a = 64'd65535;
      tab[i] = a[DATA_W-1:0];
      e = (e * q2) >> 32;
    end
    return tab;
  endfunction

  localparam alpha_tab_t ALPHA_TAB = build_alpha_tab();

endpackage

FILE: hw/rtl/vses_front.sv
// Front end: configuration registers, input accept, time-step product and alpha lookup.
// Depends on vses_pkg; feeds vses_cmd_queue.
module vses_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [vses_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vses_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             push,
  output logic                             full,
  input  logic [vses_pkg::CH_W-1:0]        in_channel,
  input  logic [vses_pkg::DATA_W-1:0]      in_time_step,
  input  logic [vses_pkg::DATA_W-1:0]      in_speed_in,
  input  logic signed [vses_pkg::DATA_W-1:0] in_accel_in,
  output logic                             cmd_push,
  input  logic                             cmd_full,
  output vses_pkg::cmd_t                   cmd_data
);

  logic                                enable_r;
  logic [vses_pkg::DATA_W-1:0]         inv_tau_r;
  logic                                f_valid_r;
  logic [vses_pkg::CH_W-1:0]           f_ch_r;
  logic [vses_pkg::DATA_W-1:0]         f_spd_r;
  logic signed [vses_pkg::DATA_W-1:0]  f_acc_r;
  logic                                f_smooth_r;
  logic [vses_pkg::PROD_W-1:0]         f_p_r;
  logic [vses_pkg::PROD_W-1:vses_pkg::ALPHA_SHIFT] p_hi;
  logic                                idx_sat;
  logic [vses_pkg::ALPHA_IDX_W-1:0]    alpha_idx;
  logic [vses_pkg::DATA_W-1:0]         alpha;
  logic                                accept;

  assign full   = f_valid_r && cmd_full;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      inv_tau_r <= vses_pkg::INV_TAU_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vses_pkg::REG_SMOOTHING_ENABLE: enable_r  <= cfg_wdata[0];
        vses_pkg::REG_INV_TAU:          inv_tau_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (!full) begin
      f_valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_ch_r     <= in_channel;
      f_spd_r    <= in_speed_in;
      f_acc_r    <= in_accel_in;
      f_smooth_r <= enable_r && (in_time_step != '0);
      f_p_r      <= in_time_step * inv_tau_r;
    end
  end

  always_comb begin
    p_hi      = f_p_r[vses_pkg::PROD_W-1:vses_pkg::ALPHA_SHIFT];
    idx_sat   = |p_hi[vses_pkg::PROD_W-1:vses_pkg::ALPHA_SHIFT+vses_pkg::ALPHA_IDX_W];
    alpha_idx = idx_sat ? '1
                        : p_hi[vses_pkg::ALPHA_SHIFT+vses_pkg::ALPHA_IDX_W-1:vses_pkg::ALPHA_SHIFT];
    alpha     = (f_p_r == '0) ? '0 : vses_pkg::ALPHA_TAB[alpha_idx];
  end

  assign cmd_push         = f_valid_r && !cmd_full;
  assign cmd_data.channel = f_ch_r;
  assign cmd_data.speed   = f_spd_r;
  assign cmd_data.accel   = f_acc_r;
  assign cmd_data.smooth  = f_smooth_r;
  assign cmd_data.alpha   = alpha;

  ap_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (f_valid_r && cmd_full) |=> (f_valid_r && $stable(f_p_r) && $stable(f_ch_r)))
    else $error("front stage dropped a blocked item");

  ap_no_push_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !f_valid_r |-> !cmd_push)
    else $error("front pushed without a held item");

  ap_full_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> (f_valid_r && !cmd_push))
    else $error("front reports full while draining");

endmodule

FILE: hw/rtl/vses_cmd_queue.sv
// Two-entry command queue between front and back ends.
// Depends on vses_pkg for the command type.
module vses_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_push,
  input  vses_pkg::cmd_t q_wdata,
  output logic           q_full,
  input  logic           q_pop,
  output logic           q_empty,
  output vses_pkg::cmd_t q_rdata
);

  vses_pkg::cmd_t entry_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           do_push;
  logic           do_pop;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_rdata = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= q_wdata;
  end

  ap_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("command queue count out of range");

  ap_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("command queue pointers disagree with count");

  ap_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("command queue lost a transfer");

endmodule

FILE: hw/rtl/vses_back.sv
// Back end: per-channel state memory, load/blend sequencer and two-entry result queue.
// Depends on vses_pkg; takes commands from vses_cmd_queue.
module vses_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cmd_empty,
  input  vses_pkg::cmd_t                     cmd_data,
  output logic                               cmd_pop,
  output logic                               empty,
  input  logic                               pop,
  output logic [vses_pkg::DATA_W-1:0]        out_speed_out,
  output logic signed [vses_pkg::DATA_W-1:0] out_accel_out
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WB} state_t;

  state_t                               state_r;
  vses_pkg::cmd_t                       work_r;
  logic [vses_pkg::CHANNELS-1:0]        valid_r;
  logic [2*vses_pkg::DATA_W-1:0]        mem_r [vses_pkg::CHANNELS];
  logic [2*vses_pkg::DATA_W-1:0]        rd_data_r;
  logic signed [33:0]                   prod_spd_r;
  logic signed [33:0]                   prod_acc_r;
  logic [vses_pkg::DATA_W-1:0]          s_spd_r;
  logic [vses_pkg::DATA_W-1:0]          s_acc_r;

  logic [vses_pkg::DATA_W-1:0]          s_spd;
  logic [vses_pkg::DATA_W-1:0]          s_acc;
  logic signed [16:0]                   diff_spd;
  logic signed [16:0]                   diff_acc;
  logic signed [16:0]                   alpha_s;
  logic signed [33:0]                   prod_spd;
  logic signed [33:0]                   prod_acc;
  logic signed [33:0]                   t_spd;
  logic signed [33:0]                   t_acc;
  logic [vses_pkg::DATA_W-1:0]          spd_new;
  logic [vses_pkg::DATA_W-1:0]          acc_new;
  logic                                 cur_valid;
  logic                                 mem_we;
  logic [2*vses_pkg::DATA_W-1:0]        mem_wdata;

  vses_pkg::res_t                       res_r [2];
  logic                                 res_wr_ptr_r;
  logic                                 res_rd_ptr_r;
  logic [1:0]                           res_cnt_r;
  logic                                 res_push;
  vses_pkg::res_t                       res_wdata;
  logic                                 res_pop;

  assign cur_valid = valid_r[work_r.channel];
  assign cmd_pop   = (state_r == S_IDLE) && !cmd_empty && (res_cnt_r < 2'd2);

  always_comb begin
    s_spd    = rd_data_r[2*vses_pkg::DATA_W-1:vses_pkg::DATA_W];
    s_acc    = rd_data_r[vses_pkg::DATA_W-1:0];
    diff_spd = $signed({1'b0, work_r.speed}) - $signed({1'b0, s_spd});
    diff_acc = $signed({work_r.accel[vses_pkg::DATA_W-1], work_r.accel})
             - $signed({s_acc[vses_pkg::DATA_W-1], s_acc});
    alpha_s  = $signed({1'b0, work_r.alpha});
    prod_spd = alpha_s * diff_spd;
    prod_acc = alpha_s * diff_acc;
    t_spd    = prod_spd_r + 34'sd32768;
    t_acc    = prod_acc_r + 34'sd32768;
    spd_new  = s_spd_r + t_spd[31:16];
    acc_new  = s_acc_r + t_acc[31:16];
  end

  always_comb begin
    res_push  = 1'b0;
    res_wdata = {cmd_data.speed, cmd_data.accel};
    mem_we    = 1'b0;
    mem_wdata = {spd_new, acc_new};
    unique case (state_r)
      S_IDLE: begin
        res_push = cmd_pop && !cmd_data.smooth;
      end
      S_READ: begin
        if (!cur_valid) begin
          res_push  = 1'b1;
          res_wdata = {work_r.speed, work_r.accel};
          mem_we    = 1'b1;
          mem_wdata = {work_r.speed, work_r.accel};
        end
      end
      S_WB: begin
        res_push  = 1'b1;
        res_wdata = {spd_new, acc_new};
        mem_we    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd_pop && cmd_data.smooth) state_r <= S_READ;
        end
        S_READ: begin
          if (!cur_valid) begin
            valid_r[work_r.channel] <= 1'b1;
            state_r                 <= S_IDLE;
          end else begin
            state_r <= S_WB;
          end
        end
        S_WB: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) work_r <= cmd_data;
    prod_spd_r <= prod_spd;
    prod_acc_r <= prod_acc;
    if (state_r == S_READ) begin
      s_spd_r <= s_spd;
      s_acc_r <= s_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[work_r.channel] <= mem_wdata;
    rd_data_r <= mem_r[cmd_data.channel];
  end

  assign res_pop       = pop && !empty;
  assign empty         = (res_cnt_r == 2'd0);
  assign out_speed_out = res_r[res_rd_ptr_r].speed;
  assign out_accel_out = res_r[res_rd_ptr_r].accel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_ptr_r <= 1'b0;
      res_rd_ptr_r <= 1'b0;
      res_cnt_r    <= 2'd0;
    end else begin
      if (res_push) res_wr_ptr_r <= !res_wr_ptr_r;
      if (res_pop)  res_rd_ptr_r <= !res_rd_ptr_r;
      res_cnt_r <= res_cnt_r + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) res_r[res_wr_ptr_r] <= res_wdata;
  end

  ap_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (res_cnt_r < 2'd2 || res_pop))
    else $error("result queue overrun");

  ap_load_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && !cur_valid) |=> valid_r[work_r.channel])
    else $error("loaded channel not marked valid");

  ap_wb_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |=> (res_cnt_r != 2'd0 && state_r == S_IDLE))
    else $error("blended result not queued");

  ap_pop_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == S_IDLE && !cmd_empty))
    else $error("command taken while busy");

endmodule

FILE: hw/rtl/variable_step_ema_smoother.sv
// Top level of the multi-channel variable-step exponential smoother.
// Depends on vses_pkg, vses_front, vses_cmd_queue and vses_back.
//
//   channel   ports                                             handshake
//   input     in_channel in_time_step in_speed_in in_accel_in   push / full
//   result    out_speed_out out_accel_out                       empty / pop
//   config    cfg_index cfg_wdata                               cfg_we
//
// The front stage takes one item per cycle while full is low and looks up alpha in
// the cycle after it accepts the item. The back end passes a pass-through item on
// from its idle state, stores a first sample on a channel from its read state and
// blends in its read and write-back states (state memory read, multiply, write back).
// Reset restores configuration defaults and clears all channel valid marks at once.
// A stalled result queue fills the back end, then the command queue, then asserts full.
module variable_step_ema_smoother (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [vses_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vses_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               push,
  output logic                               full,
  input  logic [vses_pkg::CH_W-1:0]          in_channel,
  input  logic [vses_pkg::DATA_W-1:0]        in_time_step,
  input  logic [vses_pkg::DATA_W-1:0]        in_speed_in,
  input  logic signed [vses_pkg::DATA_W-1:0] in_accel_in,
  output logic                               empty,
  input  logic                               pop,
  output logic [vses_pkg::DATA_W-1:0]        out_speed_out,
  output logic signed [vses_pkg::DATA_W-1:0] out_accel_out
);

  logic           cmd_push;
  logic           cmd_full;
  logic           cmd_pop;
  logic           cmd_empty;
  vses_pkg::cmd_t cmd_wdata;
  vses_pkg::cmd_t cmd_rdata;

  vses_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .push         (push),
    .full         (full),
    .in_channel   (in_channel),
    .in_time_step (in_time_step),
    .in_speed_in  (in_speed_in),
    .in_accel_in  (in_accel_in),
    .cmd_push     (cmd_push),
    .cmd_full     (cmd_full),
    .cmd_data     (cmd_wdata)
  );

  vses_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (cmd_push),
    .q_wdata (cmd_wdata),
    .q_full  (cmd_full),
    .q_pop   (cmd_pop),
    .q_empty (cmd_empty),
    .q_rdata (cmd_rdata)
  );

  vses_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_empty     (cmd_empty),
    .cmd_data      (cmd_rdata),
    .cmd_pop       (cmd_pop),
    .empty         (empty),
    .pop           (pop),
    .out_speed_out (out_speed_out),
    .out_accel_out (out_accel_out)
  );

endmodule

FILE: test/variable_step_ema_smoother_test.sv
// Self-checking testbench for variable_step_ema_smoother: a per-channel smoothing
// predictor checks every result transfer under idle, stall and back-pressure mixes.
// Depends on vses_pkg and the variable_step_ema_smoother RTL.
module variable_step_ema_smoother_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [vses_pkg::CH_W-1:0]       chan_t;
  typedef logic [vses_pkg::DATA_W-1:0]     word_t;
  typedef logic [vses_pkg::CFG_DATA_W-1:0] cfg_word_t;

  typedef struct packed {
    logic [vses_pkg::CH_W-1:0]          ch;
    logic [vses_pkg::DATA_W-1:0]        dt;
    logic [vses_pkg::DATA_W-1:0]        spd;
    logic signed [vses_pkg::DATA_W-1:0] acc;
  } sample_t;

  typedef struct packed {
    logic [vses_pkg::DATA_W-1:0]        speed;
    logic signed [vses_pkg::DATA_W-1:0] accel;
  } smooth_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [vses_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [vses_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;
  logic                                push = 1'b0;
  logic [vses_pkg::CH_W-1:0]           in_channel = '0;
  logic [vses_pkg::DATA_W-1:0]         in_time_step = '0;
  logic [vses_pkg::DATA_W-1:0]         in_speed_in = '0;
  logic signed [vses_pkg::DATA_W-1:0]  in_accel_in = '0;
  logic                                pop = 1'b0;
  logic                                full;
  logic                                empty;
  logic [vses_pkg::DATA_W-1:0]         out_speed_out;
  logic signed [vses_pkg::DATA_W-1:0]  out_accel_out;

  // predictor state and register mirror
  int unsigned                         gain_tab [vses_pkg::ALPHA_DEPTH];
  bit                                  ch_loaded [vses_pkg::CHANNELS];
  logic [vses_pkg::DATA_W-1:0]         held_speed [vses_pkg::CHANNELS];
  logic signed [vses_pkg::DATA_W-1:0]  held_accel [vses_pkg::CHANNELS];
  bit                                  smooth_on = 1'b0;
  logic [vses_pkg::DATA_W-1:0]         tau_q88 = vses_pkg::INV_TAU_RESET;
  smooth_t                             smoothed_due [$];

  int                        send_idle_pct = 0;
  int                        stall_pct = 0;
  logic                      hold_pop = 1'b0;
  bit                        out_taken;
  smooth_t                   out_seen;
  smooth_t                   want;
  int                        errors = 0;
  int                        samples_in = 0;
  int                        results_checked = 0;
  int                        first_loads = 0;
  int                        blends = 0;
  int                        pass_throughs = 0;
  int                        full_cycles = 0;

  variable_step_ema_smoother uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .push          (push),
    .full          (full),
    .in_channel    (in_channel),
    .in_time_step  (in_time_step),
    .in_speed_in   (in_speed_in),
    .in_accel_in   (in_accel_in),
    .empty         (empty),
    .pop           (pop),
    .out_speed_out (out_speed_out),
    .out_accel_out (out_accel_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic flag_error(string msg);
    errors++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // alpha = 1 - exp(-x) at bin centers, Q0.16, stepped by the square of exp(-h)
  function automatic void build_gain_table();
    longint unsigned hq;
    longint unsigned term;
    longint unsigned q;
    longint unsigned q2;
    longint unsigned e;
    longint unsigned one;
    longint unsigned a;
    one  = 64'd1 << 32;
    hq   = (64'd1 << 34) / longint'(vses_pkg::ALPHA_DEPTH);
    term = one;
    q    = 0;
    for (int k = 0; k < 13; k++) begin
      if (k % 2 == 1) q = q - term;
      else q = q + term;
      term = ((term * hq) >> 32) / longint'(k + 1);
    end
    q2 = (q * q) >> 32;
    e  = q;
    for (int i = 0; i < vses_pkg::ALPHA_DEPTH; i++) begin
      a = (e < one) ? ((one - e) >> 16) : 64'd0;
      if (a > 64'd65535) a = 64'd65535;
      gain_tab[i] = int'(a);
      e = (e * q2) >> 32;
    end
  endfunction

  function automatic longint ease_toward(longint cur, longint target, int unsigned gain);
    longint t;
    t = longint'(gain) * (target - cur) + 64'sd32768;
    return cur + (t >>> 16);
  endfunction

  function automatic smooth_t predict_smoothed(sample_t s);
    smooth_t          r;
    logic [31:0]      rate_prod;
    longint unsigned  slot;
    int unsigned      gain;
    r.speed = s.spd;
    r.accel = s.acc;
    if (smooth_on && s.dt != 0) begin
      if (!ch_loaded[s.ch]) begin
        held_speed[s.ch] = s.spd;
        held_accel[s.ch] = s.acc;
        ch_loaded[s.ch]  = 1'b1;
        first_loads++;
      end else begin
        rate_prod = {16'd0, s.dt} * {16'd0, tau_q88};
        gain = 0;
        if (rate_prod != 0) begin
          slot = (longint'(rate_prod) * vses_pkg::ALPHA_DEPTH) >> 27;
          if (slot > vses_pkg::ALPHA_DEPTH - 1) slot = vses_pkg::ALPHA_DEPTH - 1;
          gain = gain_tab[slot];
        end
        held_speed[s.ch] = word_t'(ease_toward(longint'($unsigned(held_speed[s.ch])),
                                               longint'($unsigned(s.spd)), gain));
        held_accel[s.ch] = word_t'(ease_toward(longint'($signed(held_accel[s.ch])),
                                               longint'($signed(s.acc)), gain));
        blends++;
      end
      r.speed = held_speed[s.ch];
      r.accel = held_accel[s.ch];
    end else begin
      pass_throughs++;
    end
    return r;
  endfunction

  function automatic sample_t sample_of(int ch, int dt, int spd, int acc);
    sample_t s;
    s.ch  = chan_t'(ch);
    s.dt  = word_t'(dt);
    s.spd = word_t'(spd);
    s.acc = word_t'(acc);
    return s;
  endfunction

  // mostly a few busy channels so back-to-back updates hit the same state
  function automatic sample_t random_sample();
    sample_t     s;
    int unsigned pick;
    pick = $urandom_range(99);
    s.ch = (pick < 50) ? chan_t'($urandom_range(3))
                       : chan_t'($urandom_range(vses_pkg::CHANNELS - 1));
    pick = $urandom_range(99);
    if (pick < 8) s.dt = '0;
    else if (pick < 48) s.dt = word_t'($urandom_range(65535, 1));
    else s.dt = word_t'($urandom_range(8191, 1));
    pick = $urandom_range(99);
    if (pick < 4) s.spd = '0;
    else if (pick < 8) s.spd = 16'd32768;
    else s.spd = word_t'($urandom_range(32768));
    s.acc = word_t'($urandom);
    return s;
  endfunction

  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    in_channel   <= s.ch;
    in_time_step <= s.dt;
    in_speed_in  <= s.spd;
    in_accel_in  <= s.acc;
    push         <= 1'b1;
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    smoothed_due.push_back(predict_smoothed(s));
    samples_in++;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (smoothed_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_register(logic [vses_pkg::CFG_IDX_W-1:0] idx,
                              logic [vses_pkg::CFG_DATA_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      vses_pkg::REG_SMOOTHING_ENABLE: smooth_on = val[0];
      vses_pkg::REG_INV_TAU:          tau_q88 = val;
      default: ;
    endcase
  endtask

  // sample capture at the falling edge, transfer check at the rising edge
  always @(negedge clk) begin
    out_taken = rst_n && pop && !empty;
    out_seen  = {out_speed_out, out_accel_out};
    if (rst_n && push && full) full_cycles++;
  end

  always @(posedge clk) begin
    if (out_taken) begin
      if (smoothed_due.size() == 0) begin
        flag_error($sformatf("result transfer with nothing expected: speed %0d accel %0d",
                             out_seen.speed, out_seen.accel));
      end else begin
        want = smoothed_due.pop_front();
        if (out_seen.speed !== want.speed)
          flag_error($sformatf("speed_out %0d, expected %0d (result %0d)",
                               out_seen.speed, want.speed, results_checked));
        if (out_seen.accel !== want.accel)
          flag_error($sformatf("accel_out %0d, expected %0d (result %0d)",
                               out_seen.accel, want.accel, results_checked));
        results_checked++;
      end
    end
    pop <= !hold_pop && ($urandom_range(99) >= stall_pct);
  end

  task automatic test_reset_passthrough();
    send_sample(sample_of(0, 100, 0, -32768));
    send_sample(sample_of(63, 65535, 32768, 32767));
  endtask

  task automatic test_directed_cases();
    set_register(vses_pkg::REG_SMOOTHING_ENABLE, 16'd1);
    send_sample(sample_of(5, 0, 1234, -5));
    send_sample(sample_of(5, 1000, 32768, 32767));
    send_sample(sample_of(5, 65535, 0, -32768));
    send_sample(sample_of(5, 1, 32768, 32767));
    send_sample(sample_of(5, 0, 7, 7));
    send_sample(sample_of(63, 50, 100, -100));
    send_sample(sample_of(63, 50, 32768, 32767));
    send_sample(sample_of(63, 50, 0, -32768));
    send_sample(sample_of(0, 20000, 16384, 256));
    send_sample(sample_of(0, 20000, 16384, 256));
    set_register(vses_pkg::REG_INV_TAU, 16'hFFFF);
    send_sample(sample_of(0, 65535, 32768, -32768));
    send_sample(sample_of(0, 1, 0, 32767));
    set_register(vses_pkg::REG_INV_TAU, 16'd0);
    send_sample(sample_of(5, 40000, 32768, 32767));
    send_sample(sample_of(63, 65535, 0, 0));
    set_register(vses_pkg::REG_INV_TAU, 16'd1);
    send_sample(sample_of(0, 65535, 0, 0));
    set_register(vses_pkg::REG_SMOOTHING_ENABLE, 16'd0);
    send_sample(sample_of(5, 300, 1, -1));
  endtask

  task automatic test_random_traffic(int count, int idle, int stall);
    send_idle_pct = idle;
    stall_pct <= stall;
    repeat (count) send_sample(random_sample());
  endtask

  // hold the result side off long enough for the block to fill and assert full
  task automatic test_backpressure();
    send_idle_pct = 0;
    fork
      begin
        hold_pop <= 1'b1;
        repeat (400) @(posedge clk);
        hold_pop <= 1'b0;
      end
      repeat (60) send_sample(random_sample());
    join
  endtask

  initial begin
    build_gain_table();
    for (int i = 0; i < vses_pkg::CHANNELS; i++) ch_loaded[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_passthrough();
    test_directed_cases();

    set_register(vses_pkg::REG_SMOOTHING_ENABLE, 16'd1);
    set_register(vses_pkg::REG_INV_TAU, vses_pkg::INV_TAU_RESET);
    test_random_traffic(270, 0, 0);
    set_register(vses_pkg::REG_INV_TAU, 16'd1);
    test_random_traffic(270, 86, 0);
    set_register(vses_pkg::REG_INV_TAU, 16'hFFFF);
    test_random_traffic(270, 0, 86);
    set_register(vses_pkg::REG_INV_TAU, 16'd300);
    test_random_traffic(270, 29, 29);
    set_register(vses_pkg::REG_SMOOTHING_ENABLE, 16'hFFFE);
    test_random_traffic(120, 0, 0);
    set_register(vses_pkg::REG_SMOOTHING_ENABLE, 16'h8001);
    set_register(vses_pkg::REG_INV_TAU, 16'd0);
    test_random_traffic(120, 29, 29);
    set_register(vses_pkg::REG_INV_TAU, cfg_word_t'($urandom_range(65535, 1)));
    test_random_traffic(270, 0, 0);
    set_register(vses_pkg::REG_INV_TAU, 16'd2000);
    test_random_traffic(270, 29, 29);
    set_register(vses_pkg::REG_INV_TAU, vses_pkg::INV_TAU_RESET);
    stall_pct <= 0;
    test_backpressure();
    settle();

    if (smoothed_due.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", smoothed_due.size()));
    $display("Sent %0d samples and checked %0d results: %0d first loads, %0d blends, %0d %s",
             samples_in, results_checked, first_loads, blends, pass_throughs,
             "passed through.");
    $display("Inputs were held off by a full block for %0d cycles across all mixes.",
             full_cycles);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
